/* design/vfsc_pkg.sv */
package vfsc_pkg;

  localparam int MATRIX_ELEMS = 16;
  localparam int DATA_W       = 32;
  localparam int PROD_W       = 48;
  localparam int SUM_W        = 50;
  localparam int DIST_W       = 63;
  localparam int DIV_STEPS    = 48;
  localparam int DIV_LAT      = DIV_STEPS + 2;
  localparam int NUM_PLANES   = 6;
  localparam int CNT_W        = 7;
  localparam int CMD_W        = 2;
  localparam int IN_DATA_W    = 200;
  localparam int OUT_DATA_W   = 128;

  typedef logic signed [DATA_W-1:0] q16_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [SUM_W-1:0]  sum_t;
  typedef logic [DIST_W-1:0]        dist_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD_MV = 2'd0,
    CMD_LOAD_PJ = 2'd1,
    CMD_QUERY   = 2'd2
  } cmd_t;

  localparam q16_t  Q_MAX    = {1'b0, {(DATA_W-1){1'b1}}};
  localparam q16_t  Q_MIN    = {1'b1, {(DATA_W-1){1'b0}}};
  localparam dist_t DIST_MAX = {DIST_W{1'b1}};

  // q16.16 product floored back to q16.16, kept at full range
  function automatic prod_t qmul(input q16_t a, input q16_t b);
    logic signed [2*DATA_W-1:0] p;
    p = (2*DATA_W)'(a) * (2*DATA_W)'(b);
    return p[2*DATA_W-1:16];
  endfunction

  // clamp a wide signed sum to the q16.16 range
  function automatic q16_t sat32(input sum_t v);
    if (v[SUM_W-1:DATA_W-1] == '0 || v[SUM_W-1:DATA_W-1] == '1) begin
      return v[DATA_W-1:0];
    end else if (v[SUM_W-1]) begin
      return Q_MIN;
    end else begin
      return Q_MAX;
    end
  endfunction

endpackage

/* design/vfsc_div.sv */
module vfsc_div (
  input  logic            clk,
  input  logic            en,
  input  vfsc_pkg::q16_t  num_i,
  input  vfsc_pkg::q16_t  den_i,
  output vfsc_pkg::q16_t  quo_o
);
  import vfsc_pkg::*;

  typedef struct packed {
    logic [DIV_STEPS-1:0] nq;
    logic [DATA_W-1:0]    rem;
    logic [DATA_W-1:0]    dm;
    logic                 neg;
    logic                 dz;
    q16_t                 a;
  } div_st_t;

  div_st_t st_r [DIV_STEPS+1];
  q16_t    quo_r;

  // one restoring step: shift in a numerator bit, subtract if it fits
  function automatic div_st_t div_step(input div_st_t s);
    logic [DATA_W:0] sh;
    logic            ge;
    div_st_t         o;
    o  = s;
    sh = {s.rem, s.nq[DIV_STEPS-1]};
    ge = (sh >= {1'b0, s.dm});
    o.rem = ge ? DATA_W'(sh - {1'b0, s.dm}) : sh[DATA_W-1:0];
    o.nq  = {s.nq[DIV_STEPS-2:0], ge};
    return o;
  endfunction

  logic [DATA_W-1:0]    amag;
  logic [DATA_W-1:0]    dmag;
  logic [DIV_STEPS-1:0] q;

  assign amag = num_i[DATA_W-1] ? (~num_i + 1'b1) : num_i;
  assign dmag = den_i[DATA_W-1] ? (~den_i + 1'b1) : den_i;
  assign q    = st_r[DIV_STEPS].nq;

  // magnitude setup, step chain and signed saturating result; a zero divisor passes the numerator
  always_ff @(posedge clk) begin
    if (en) begin
      st_r[0].nq  <= {amag, 16'b0};
      st_r[0].rem <= '0;
      st_r[0].dm  <= dmag;
      st_r[0].neg <= num_i[DATA_W-1] ^ den_i[DATA_W-1];
      st_r[0].dz  <= (den_i == '0);
      st_r[0].a   <= num_i;
      for (int k = 0; k < DIV_STEPS; k++) begin
        st_r[k+1] <= div_step(st_r[k]);
      end
      if (st_r[DIV_STEPS].dz) begin
        quo_r <= st_r[DIV_STEPS].a;
      end else if (st_r[DIV_STEPS].neg) begin
        if (q > DIV_STEPS'({1'b1, {(DATA_W-1){1'b0}}})) begin
          quo_r <= Q_MIN;
        end else begin
          quo_r <= ~q[DATA_W-1:0] + 1'b1;
        end
      end else begin
        if (q > DIV_STEPS'({(DATA_W-1){1'b1}})) begin
          quo_r <= Q_MAX;
        end else begin
          quo_r <= q[DATA_W-1:0];
        end
      end
    end
  end

  assign quo_o = quo_r;

endmodule

/* design/vfsc_plane.sv */
module vfsc_plane (
  input  logic            clk,
  input  logic            en,
  input  vfsc_pkg::q16_t  n_i [3],
  input  vfsc_pkg::q16_t  coef_i [4],
  input  vfsc_pkg::q16_t  rad_i,
  output logic            outside_o
);
  import vfsc_pkg::*;

  prod_t              pr_r [3];
  logic signed [DATA_W:0] bias_r;
  logic               outside_r;
  sum_t               s;

  assign s = SUM_W'(pr_r[0]) + SUM_W'(pr_r[1]) + SUM_W'(pr_r[2]) + SUM_W'(bias_r);

  // products first, then the plane distance sign
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        pr_r[i] <= qmul(n_i[i], coef_i[i]);
      end
      bias_r    <= (DATA_W+1)'(coef_i[3]) + (DATA_W+1)'(rad_i);
      outside_r <= s[SUM_W-1];
    end
  end

  assign outside_o = outside_r;

endmodule

/* design/view_frustum_sphere_cull_top.sv */
// throughput: one word per cycle while the skid word is empty
// the 48-step quotient pipes set the depth
// a load word waits at the input until no query is left in flight
// reset: synchronous active-low rst_n clears both matrices, valids and counters
module view_frustum_sphere_cull_top (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // elem_index, elem_value, pos_x, pos_y, pos_z, pos_w, radius, zero pad
  input  logic [vfsc_pkg::IN_DATA_W-1:0]     in_tdata,
  // cmd
  input  logic [vfsc_pkg::CMD_W-1:0]         in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // visible, dist_sqr, screen_x, screen_y
  output logic [vfsc_pkg::OUT_DATA_W-1:0]    out_tdata
);
  import vfsc_pkg::*;

  localparam int PL_ROW [NUM_PLANES] = '{2, 1, 1, 0, 0, 2};
  localparam bit PL_ADD [NUM_PLANES] = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0};
  localparam int SC_ROW [3]          = '{0, 1, 3};

  typedef struct packed {
    logic  q;
    q16_t  sy;
    q16_t  sx;
    dist_t dsq;
    logic  vis;
  } res_t;

  typedef struct packed {
    logic  q;
    dist_t dsq;
    q16_t  rad;
  } side_t;

  // input decode
  cmd_t  cmd;
  logic  is_load;
  logic  in_fire;
  logic  en;
  q16_t  in_pos [4];
  q16_t  in_rad;
  q16_t  in_val;
  logic [3:0] in_idx;

  assign cmd       = cmd_t'(in_tuser);
  assign is_load   = (cmd == CMD_LOAD_MV) || (cmd == CMD_LOAD_PJ);
  assign in_idx    = in_tdata[3:0];
  assign in_val    = in_tdata[35:4];
  assign in_pos[0] = in_tdata[67:36];
  assign in_pos[1] = in_tdata[99:68];
  assign in_pos[2] = in_tdata[131:100];
  assign in_pos[3] = in_tdata[163:132];
  assign in_rad    = in_tdata[195:164];

  logic skd_valid_r;
  logic [CNT_W-1:0] cnt_r;

  assign en        = !skd_valid_r;
  assign in_tready = en && !(is_load && cnt_r != '0);
  assign in_fire   = in_tvalid && in_tready;

  // matrices
  q16_t mv_r [MATRIX_ELEMS];
  q16_t pj_r [MATRIX_ELEMS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MATRIX_ELEMS; i++) begin
        mv_r[i] <= '0;
        pj_r[i] <= '0;
      end
    end else if (in_fire) begin
      case (cmd)
        CMD_LOAD_MV: mv_r[in_idx] <= in_val;
        CMD_LOAD_PJ: pj_r[in_idx] <= in_val;
        default: ;
      endcase
    end
  end

  // plane coefficients follow the projection matrix
  q16_t coef_r [NUM_PLANES][4];

  always_ff @(posedge clk) begin
    for (int p = 0; p < NUM_PLANES; p++) begin
      for (int k = 0; k < 4; k++) begin
        if (PL_ADD[p]) begin
          coef_r[p][k] <= sat32(SUM_W'(pj_r[4*k+3]) + SUM_W'(pj_r[4*k+PL_ROW[p]]));
        end else begin
          coef_r[p][k] <= sat32(SUM_W'(pj_r[4*k+3]) - SUM_W'(pj_r[4*k+PL_ROW[p]]));
        end
      end
    end
  end

  // front stage valids and query flags
  logic [4:0] vld_r;
  logic [4:0] qry_r;
  q16_t       rad_r [5];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      qry_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[3:0], in_fire};
      qry_r <= {qry_r[3:0], in_fire && cmd == CMD_QUERY};
    end
  end

  q16_t  pos_r [4];
  prod_t mvp_r [4][4];
  sum_t  wa_r [4];
  q16_t  e2_r [4];
  dist_t sq_r [3];
  q16_t  eye_r [4];
  prod_t pp_r [4][3];
  dist_t dpart_r;
  dist_t dc_r;
  q16_t  eye4_r [4];
  q16_t  scr_r [3];

  // squares of the eye point, saturated
  dist_t sq_nxt [3];
  logic [SUM_W-1:0]    mag;
  logic [2*DATA_W-1:0] sq;

  always_comb begin
    mag = '0;
    sq  = '0;
    for (int r = 0; r < 3; r++) begin
      mag = wa_r[r][SUM_W-1] ? (~wa_r[r] + 1'b1) : wa_r[r];
      sq  = (2*DATA_W)'(mag[DATA_W-1:0]) * (2*DATA_W)'(mag[DATA_W-1:0]);
      if (|mag[SUM_W-1:DATA_W] || sq[2*DATA_W-1]) begin
        sq_nxt[r] = DIST_MAX;
      end else begin
        sq_nxt[r] = sq[DIST_W-1:0];
      end
    end
  end

  // first partial distance sum
  logic [DIST_W:0] dsum1;
  assign dsum1 = {1'b0, sq_r[0]} + {1'b0, sq_r[1]};

  // front stages: model-view products, sums, squares, projection, screen sums
  always_ff @(posedge clk) begin
    if (en) begin
      pos_r    <= in_pos;
      rad_r[0] <= in_rad;
      for (int i = 1; i < 5; i++) begin
        rad_r[i] <= rad_r[i-1];
      end
      for (int c = 0; c < 4; c++) begin
        for (int r = 0; r < 4; r++) begin
          mvp_r[c][r] <= qmul(pos_r[c], mv_r[4*c+r]);
        end
      end
      for (int r = 0; r < 4; r++) begin
        wa_r[r] <= SUM_W'(mvp_r[0][r]) + SUM_W'(mvp_r[1][r]) + SUM_W'(mvp_r[2][r]) +
                   SUM_W'(mv_r[12+r]);
        e2_r[r] <= sat32(SUM_W'(mvp_r[0][r]) + SUM_W'(mvp_r[1][r]) +
                         SUM_W'(mvp_r[2][r]) + SUM_W'(mvp_r[3][r]));
        eye_r[r] <= sat32(wa_r[r]);
      end
      sq_r <= sq_nxt;
      for (int c = 0; c < 4; c++) begin
        for (int j = 0; j < 3; j++) begin
          pp_r[c][j] <= qmul(e2_r[c], pj_r[4*c+SC_ROW[j]]);
        end
      end
      dpart_r <= dsum1[DIST_W] ? DIST_MAX : dsum1[DIST_W-1:0];
      dc_r    <= sq_r[2];
      eye4_r  <= eye_r;
      for (int j = 0; j < 3; j++) begin
        scr_r[j] <= sat32(SUM_W'(pp_r[0][j]) + SUM_W'(pp_r[1][j]) +
                          SUM_W'(pp_r[2][j]) + SUM_W'(pp_r[3][j]));
      end
    end
  end

  // homogeneous divides: three eye lanes, two screen lanes
  q16_t nrm [3];
  q16_t sxy [2];

  for (genvar i = 0; i < 3; i++) begin : g_eye_div
    vfsc_div u_div (
      .clk   (clk),
      .en    (en),
      .num_i (eye4_r[i]),
      .den_i (eye4_r[3]),
      .quo_o (nrm[i])
    );
  end

  for (genvar i = 0; i < 2; i++) begin : g_scr_div
    vfsc_div u_div (
      .clk   (clk),
      .en    (en),
      .num_i (scr_r[i]),
      .den_i (scr_r[2]),
      .quo_o (sxy[i])
    );
  end

  // sideband alongside the dividers, final distance add on entry
  logic [DIST_W:0]      dsum2;
  logic [DIV_LAT-1:0]   sbv_r;
  side_t                sb_r [DIV_LAT];

  assign dsum2 = {1'b0, dpart_r} + {1'b0, dc_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sbv_r <= '0;
    end else if (en) begin
      sbv_r <= {sbv_r[DIV_LAT-2:0], vld_r[4]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sb_r[0].q    <= qry_r[4];
      sb_r[0].dsq  <= dsum2[DIST_W] ? DIST_MAX : dsum2[DIST_W-1:0];
      sb_r[0].rad  <= rad_r[4];
      for (int i = 1; i < DIV_LAT; i++) begin
        sb_r[i] <= sb_r[i-1];
      end
    end
  end

  // six plane tests
  logic [NUM_PLANES-1:0] outside;

  for (genvar p = 0; p < NUM_PLANES; p++) begin : g_plane
    vfsc_plane u_plane (
      .clk       (clk),
      .en        (en),
      .n_i       (nrm),
      .coef_i    (coef_r[p]),
      .rad_i     (sb_r[DIV_LAT-1].rad),
      .outside_o (outside[p])
    );
  end

  // delay matching the plane test
  logic [1:0] pv_r;
  logic [1:0] pq_r;
  dist_t      pd_r [2];
  q16_t       psx_r [2];
  q16_t       psy_r [2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= '0;
    end else if (en) begin
      pv_r <= {pv_r[0], sbv_r[DIV_LAT-1]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pq_r     <= {pq_r[0], sb_r[DIV_LAT-1].q};
      pd_r[0]  <= sb_r[DIV_LAT-1].dsq;
      pd_r[1]  <= pd_r[0];
      psx_r[0] <= sxy[0];
      psx_r[1] <= psx_r[0];
      psy_r[0] <= sxy[1];
      psy_r[1] <= psy_r[0];
    end
  end

  // last stage word, zero for loads and unused commands
  res_t last;
  logic fire;

  assign fire      = en && pv_r[1];
  assign last.q    = pq_r[1];
  assign last.vis  = pq_r[1] && !(|outside);
  assign last.dsq  = pq_r[1] ? pd_r[1] : '0;
  assign last.sx   = pq_r[1] ? psx_r[1] : '0;
  assign last.sy   = pq_r[1] ? psy_r[1] : '0;

  // output register with skid word
  logic out_valid_r;
  res_t out_r;
  res_t skd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skd_valid_r <= 1'b0;
    end else if (out_valid_r && out_tready) begin
      if (skd_valid_r) begin
        out_r       <= skd_r;
        skd_valid_r <= 1'b0;
      end else if (fire) begin
        out_r <= last;
      end else begin
        out_valid_r <= 1'b0;
      end
    end else if (!out_valid_r) begin
      if (fire) begin
        out_r       <= last;
        out_valid_r <= 1'b1;
      end
    end else if (fire) begin
      skd_r       <= last;
      skd_valid_r <= 1'b1;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_r[OUT_DATA_W-1:0];

  // queries in flight, gates matrix loads
  logic cnt_inc;
  logic cnt_dec;

  assign cnt_inc = in_fire && cmd == CMD_QUERY;
  assign cnt_dec = out_valid_r && out_tready && out_r.q;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cnt_inc && !cnt_dec) begin
      cnt_r <= cnt_r + 1'b1;
    end else if (cnt_dec && !cnt_inc) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule

/* dv/vfsc_checker.sv */
// watches both streams, predicts each result word and compares it
module vfsc_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  input  logic [vfsc_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic [vfsc_pkg::CMD_W-1:0]      in_tuser,
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic [vfsc_pkg::OUT_DATA_W-1:0] out_tdata,
  output int                              errors,
  output int                              pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import vfsc_pkg::*;

  localparam longint unsigned DSQ_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam int ONE_Q = 65536;

  // shadow copies of both matrices, column-major
  int modelview_shadow [MATRIX_ELEMS];
  int projection_shadow[MATRIX_ELEMS];
  logic [OUT_DATA_W-1:0] expected_words[$];

  // floored q16.16 product, exact
  function automatic longint mul_floor(int a, int b);
    longint p;
    p = longint'(a) * longint'(b);
    return p >>> 16;
  endfunction

  function automatic int clamp_q(longint v);
    if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return int'(v);
  endfunction

  // wide[r] = sum over c of floor(v[c] * m[c*4+r])
  function automatic void xform(input int m[MATRIX_ELEMS], input int v[4],
                                output longint wide[4]);
    for (int r = 0; r < 4; r++) begin
      wide[r] = mul_floor(v[0], m[r]) + mul_floor(v[1], m[4+r]) +
                mul_floor(v[2], m[8+r]) + mul_floor(v[3], m[12+r]);
    end
  endfunction

  // homogeneous divide, skipped when w is zero
  function automatic void persp_div(inout int v[4]);
    longint num;
    if (v[3] != 0) begin
      for (int i = 0; i < 3; i++) begin
        num = longint'(v[i]) * ONE_Q;
        v[i] = clamp_q(num / longint'(v[3]));
      end
      v[3] = ONE_Q;
    end
  endfunction

  function automatic bit beyond_plane(int n[4], int row, int sgn, int rad);
    longint a, b, s;
    int c[4];
    for (int k = 0; k < 4; k++) begin
      a = projection_shadow[k*4+row];
      b = projection_shadow[k*4+3];
      c[k] = clamp_q(sgn > 0 ? b + a : b - a);
    end
    s = mul_floor(n[0], c[0]) + mul_floor(n[1], c[1]) + mul_floor(n[2], c[2]) +
        longint'(c[3]) + longint'(rad);
    return s < 0;
  endfunction

  function automatic longint unsigned square_sat(longint v);
    longint unsigned a, s;
    a = v < 0 ? longint'(0) - v : v;
    if (a > 64'hFFFF_FFFF) return DSQ_MAX;
    s = a * a;
    return s > DSQ_MAX ? DSQ_MAX : s;
  endfunction

  function automatic longint unsigned add_dsq(longint unsigned a, longint unsigned b);
    longint unsigned s;
    s = a + b;
    return s > DSQ_MAX ? DSQ_MAX : s;
  endfunction

  // applies one word to the shadow state and returns its result word
  function automatic logic [OUT_DATA_W-1:0] cull_predict(logic [CMD_W-1:0] cmd,
                                                         logic [IN_DATA_W-1:0] d);
    int idx, val, px, py, pz, pw, rad;
    int v[4], eye[4], scr[4];
    longint wide[4];
    longint unsigned dsq;
    bit vis;
    idx = d[3:0];
    val = d[35:4];
    px  = d[67:36];
    py  = d[99:68];
    pz  = d[131:100];
    pw  = d[163:132];
    rad = d[195:164];
    case (cmd)
      CMD_LOAD_MV: begin
        modelview_shadow[idx] = val;
        return '0;
      end
      CMD_LOAD_PJ: begin
        projection_shadow[idx] = val;
        return '0;
      end
      CMD_QUERY: begin
        // sphere test and distance with w fixed at one
        v = '{px, py, pz, ONE_Q};
        xform(modelview_shadow, v, wide);
        dsq = add_dsq(add_dsq(square_sat(wide[0]), square_sat(wide[1])),
                      square_sat(wide[2]));
        for (int i = 0; i < 4; i++) eye[i] = clamp_q(wide[i]);
        persp_div(eye);
        vis = !(beyond_plane(eye, 2, 1, rad) || beyond_plane(eye, 1, 1, rad) ||
                beyond_plane(eye, 1, -1, rad) || beyond_plane(eye, 0, 1, rad) ||
                beyond_plane(eye, 0, -1, rad) || beyond_plane(eye, 2, -1, rad));
        // screen position with the given w
        v = '{px, py, pz, pw};
        xform(modelview_shadow, v, wide);
        for (int i = 0; i < 4; i++) eye[i] = clamp_q(wide[i]);
        xform(projection_shadow, eye, wide);
        for (int i = 0; i < 4; i++) scr[i] = clamp_q(wide[i]);
        persp_div(scr);
        return {scr[1], scr[0], dsq[62:0], vis};
      end
      default: return '0;
    endcase
  endfunction

  // predict on input words, compare on output words
  always @(posedge clk) begin
    logic [OUT_DATA_W-1:0] want;
    if (!rst_n) begin
      foreach (modelview_shadow[i]) modelview_shadow[i] = 0;
      foreach (projection_shadow[i]) projection_shadow[i] = 0;
      expected_words.delete();
      errors = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_words.size() == 0) begin
          $display("%0t: unexpected word %h", $time, out_tdata);
          errors++;
        end else begin
          want = expected_words.pop_front();
          if (want[0] !== out_tdata[0]) begin
            $display("%0t: visible exp %b got %b", $time, want[0], out_tdata[0]);
            errors++;
          end
          if (want[63:1] !== out_tdata[63:1]) begin
            $display("%0t: dist_sqr exp %h got %h", $time, want[63:1], out_tdata[63:1]);
            errors++;
          end
          if (want[95:64] !== out_tdata[95:64]) begin
            $display("%0t: screen_x exp %h got %h", $time, want[95:64],
                     out_tdata[95:64]);
            errors++;
          end
          if (want[127:96] !== out_tdata[127:96]) begin
            $display("%0t: screen_y exp %h got %h", $time, want[127:96],
                     out_tdata[127:96]);
            errors++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        expected_words.push_back(cull_predict(in_tuser, in_tdata));
      end
    end
    pending = expected_words.size();
  end

endmodule

/* dv/tb.sv */
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import vfsc_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int ONE_Q      = 65536;
  localparam int STALL_LIMIT = 20000;
  localparam int HOLD_CYCLES = 300;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic [CMD_W-1:0]      in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  int errors;
  int pending;
  int in_idle_pct;
  int out_idle_pct;
  bit hold_req;

  view_frustum_sphere_cull_top u_dut (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata
  );

  vfsc_checker u_checker (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata, .errors, .pending
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    bit hold_done;
    hold_done  = 1'b0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        out_tready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_done = 1'b1;
      end
      out_tready = $urandom_range(99) >= out_idle_pct;
    end
  end

  // watchdog on cycles with no word moving
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet = 0;
      else quiet++;
      if (quiet >= STALL_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // mostly small values, sometimes extremes or any bit pattern
  function automatic logic [31:0] rand_q();
    int s;
    case ($urandom_range(9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2, 3: return $urandom;
      4: return 0;
      default: begin
        s = int'($urandom_range(524287)) - 262144;
        return s;
      end
    endcase
  endfunction

  function automatic logic [IN_DATA_W-1:0] pack_word(logic [3:0] idx, logic [31:0] val,
      logic [31:0] px, logic [31:0] py, logic [31:0] pz, logic [31:0] pw,
      logic [31:0] rad);
    return {4'b0, rad, pw, pz, py, px, val, idx};
  endfunction

  task automatic send_word(logic [CMD_W-1:0] cmd, logic [IN_DATA_W-1:0] d);
    while ($urandom_range(99) < in_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = cmd;
    in_tdata  = d;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  task automatic load_elem(logic [CMD_W-1:0] cmd, int idx, int val);
    send_word(cmd, pack_word(4'(idx), val, $urandom, $urandom, $urandom, $urandom,
                             $urandom));
  endtask

  task automatic query(int px, int py, int pz, int pw, int rad);
    send_word(CMD_QUERY, pack_word(4'($urandom), $urandom, px, py, pz, pw, rad));
  endtask

  task automatic send_random();
    int r;
    r = $urandom_range(99);
    if (r < 25) load_elem(CMD_LOAD_MV, $urandom_range(15), rand_q());
    else if (r < 40) load_elem(CMD_LOAD_PJ, $urandom_range(15), rand_q());
    else if (r < 95) begin
      query(rand_q(), rand_q(), rand_q(),
            $urandom_range(3) == 0 ? ONE_Q : rand_q(), rand_q());
    end else begin
      send_word(CMD_UNUSED, IN_DATA_W'({$urandom, $urandom, $urandom, $urandom,
                                        $urandom, $urandom, $urandom}));
    end
  endtask

  task automatic wait_drained();
    while (pending != 0) @(negedge clk);
  endtask

  initial begin
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_tuser     = CMD_LOAD_MV;
    hold_req     = 1'b0;
    in_idle_pct  = 0;
    out_idle_pct = 0;
    rst_n        = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: query against zero matrices, then simple frustum
    query(ONE_Q, ONE_Q, ONE_Q, ONE_Q, ONE_Q);
    for (int i = 0; i < 4; i++) load_elem(CMD_LOAD_MV, i*5, ONE_Q);
    load_elem(CMD_LOAD_PJ, 0, ONE_Q);
    load_elem(CMD_LOAD_PJ, 5, ONE_Q);
    load_elem(CMD_LOAD_PJ, 10, -ONE_Q);
    load_elem(CMD_LOAD_PJ, 11, -ONE_Q);
    load_elem(CMD_LOAD_PJ, 14, -2*ONE_Q);
    query(0, 0, -5*ONE_Q, ONE_Q, ONE_Q);
    query(20*ONE_Q, 0, -5*ONE_Q, ONE_Q, ONE_Q);
    // zero w, negative w, negative radius
    query(ONE_Q, ONE_Q, -3*ONE_Q, 0, ONE_Q);
    query(ONE_Q, ONE_Q, -3*ONE_Q, -ONE_Q, ONE_Q);
    query(0, 0, -5*ONE_Q, ONE_Q, -100*ONE_Q);
    // extreme coordinates saturate distance and screen
    query(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    query(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1, 32'h8000_0000);
    // extreme matrix elements and the unused command
    load_elem(CMD_LOAD_MV, 0, 32'h7FFF_FFFF);
    load_elem(CMD_LOAD_PJ, 15, 32'h8000_0000);
    send_word(CMD_UNUSED, '1);
    query(32'h7FFF_FFFF, ONE_Q, -ONE_Q, ONE_Q, 0);
    query(-ONE_Q, 32'h7FFF_FFFF, 0, -1, 32'h8000_0000);

    // random phase 1 with a long receiver hold-off at its start
    in_idle_pct  = 21;
    out_idle_pct = 59;
    hold_req     = 1'b1;
    repeat (250) send_random();

    // random phase 2, then the sender waits for all results
    in_idle_pct  = 59;
    out_idle_pct = 21;
    repeat (250) send_random();
    wait_drained();

    // random phase 3, no idling
    in_idle_pct  = 0;
    out_idle_pct = 0;
    repeat (250) send_random();

    wait_drained();
    repeat (80) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* files.f */
design/vfsc_pkg.sv
design/vfsc_div.sv
design/vfsc_plane.sv
design/view_frustum_sphere_cull_top.sv
dv/vfsc_checker.sv
dv/tb.sv
